### rtl/core/scl_pkg.sv
`timescale 1ns / 1ps
package scl_pkg;

  localparam int unsigned LineBitsDef   = 16;
  localparam int unsigned PosBitsDef    = 20;
  localparam int unsigned MaxTokLenDef  = 255;
  localparam int unsigned PrefixDepth   = 7;
  localparam int unsigned KindW         = 6;
  localparam int unsigned LenW          = 8;
  localparam int unsigned ErrW          = 2;

  localparam logic [KindW-1:0] KIND_END    = 6'd0;
  localparam logic [KindW-1:0] KIND_IDENT  = 6'd32;
  localparam logic [KindW-1:0] KIND_NUMBER = 6'd33;
  localparam logic [KindW-1:0] KIND_STRING = 6'd34;

  localparam logic [ErrW-1:0] ERR_NONE    = 2'd0;
  localparam logic [ErrW-1:0] ERR_STRING  = 2'd1;
  localparam logic [ErrW-1:0] ERR_COMMENT = 2'd2;
  localparam logic [ErrW-1:0] ERR_SYMBOL  = 2'd3;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_IDENT   = 6'b000010,
    MODE_NUMBER  = 6'b000100,
    MODE_STRING  = 6'b001000,
    MODE_SYMBOL  = 6'b010000,
    MODE_COMMENT = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             line_dec;
    logic             err_flag;
    logic [ErrW-1:0]  err;
    logic             last;
    logic             use_pos;
  } tok_ctl_t;

  typedef logic [PrefixDepth-1:0][7:0] prefix_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0b) || (c == 8'h0c) || (c == 8'h0d);
  endfunction

  function automatic logic [KindW-1:0] single_kind(input logic [7:0] c);
    logic [KindW-1:0] k;
    k = KIND_END;
    case (c)
      8'h3b: k = 6'd11;
      8'h2c: k = 6'd12;
      8'h5b: k = 6'd13;
      8'h5d: k = 6'd14;
      8'h7b: k = 6'd15;
      8'h7d: k = 6'd16;
      8'h28: k = 6'd17;
      8'h29: k = 6'd18;
      8'h2b: k = 6'd25;
      8'h2d: k = 6'd26;
      8'h2a: k = 6'd27;
      8'h25: k = 6'd29;
      8'h26: k = 6'd31;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  function automatic logic [KindW-1:0] word_kind(input prefix_t p, input logic [LenW-1:0] n);
    logic [KindW-1:0] k;
    k = KIND_IDENT;
    if (n == 8'd3 && p[0] == "i" && p[1] == "n" && p[2] == "t") k = 6'd1;
    else if (n == 8'd4 && p[0] == "v" && p[1] == "o" && p[2] == "i" && p[3] == "d") k = 6'd2;
    else if (n == 8'd6 && p[0] == "s" && p[1] == "t" && p[2] == "r" && p[3] == "i" &&
             p[4] == "n" && p[5] == "g") k = 6'd3;
    else if (n == 8'd2 && p[0] == "i" && p[1] == "f") k = 6'd4;
    else if (n == 8'd4 && p[0] == "e" && p[1] == "l" && p[2] == "s" && p[3] == "e") k = 6'd5;
    else if (n == 8'd5 && p[0] == "w" && p[1] == "h" && p[2] == "i" && p[3] == "l" &&
             p[4] == "e") k = 6'd6;
    else if (n == 8'd6 && p[0] == "r" && p[1] == "e" && p[2] == "t" && p[3] == "u" &&
             p[4] == "r" && p[5] == "n") k = 6'd7;
    else if (n == 8'd5 && p[0] == "w" && p[1] == "r" && p[2] == "i" && p[3] == "t" &&
             p[4] == "e") k = 6'd8;
    else if (n == 8'd7 && p[0] == "w" && p[1] == "r" && p[2] == "i" && p[3] == "t" &&
             p[4] == "e" && p[5] == "l" && p[6] == "n") k = 6'd9;
    else if (n == 8'd4 && p[0] == "r" && p[1] == "e" && p[2] == "a" && p[3] == "d") k = 6'd10;
    return k;
  endfunction

endpackage

### rtl/core/scl_front.sv
`timescale 1ns / 1ps
module scl_front import scl_pkg::*; #(
  parameter int unsigned PosBits  = PosBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [7:0]          char_in_i,
  input  logic                end_of_input_i,
  output logic                req_valid_o,
  input  logic                req_ready_i,
  output logic [7:0]          req_char_o,
  output logic                req_eoi_o,
  output logic [PosBits-1:0]  req_pos_o
);

  logic [7:0]         char_q;
  logic               eoi_q;
  logic [PosBits-1:0] pos_q;
  logic               valid_q;
  logic [PosBits-1:0] bpos_q;
  logic               accept;

  assign full_o  = valid_q && !req_ready_i;
  assign accept  = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      bpos_q  <= '0;
    end else begin
      if (accept) begin
        valid_q <= 1'b1;
        if (!end_of_input_i) bpos_q <= bpos_q + 1'b1;
      end else if (req_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_in_i;
      eoi_q  <= end_of_input_i;
      pos_q  <= bpos_q;
    end
  end

  assign req_valid_o = valid_q;
  assign req_char_o  = char_q;
  assign req_eoi_o   = eoi_q;
  assign req_pos_o   = pos_q;

endmodule

### rtl/core/scl_back.sv
`timescale 1ns / 1ps
module scl_back import scl_pkg::*; #(
  parameter int unsigned LineBits  = LineBitsDef,
  parameter int unsigned PosBits   = PosBitsDef,
  parameter int unsigned MaxTokLen = MaxTokLenDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic [7:0]           req_char_i,
  input  logic                 req_eoi_i,
  input  logic [PosBits-1:0]   req_pos_i,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [KindW-1:0]     token_kind_o,
  output logic [LineBits-1:0]  line_number_o,
  output logic [PosBits-1:0]   start_offset_o,
  output logic [LenW-1:0]      token_length_o,
  output logic [ErrW-1:0]      error_code_o,
  output logic                 last_of_run_o
);

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [LineBits-1:0] line;
    logic [PosBits-1:0]  start;
    logic [LenW-1:0]     len;
    logic [ErrW-1:0]     err;
    logic                last;
  } res_t;

  localparam logic [LenW-1:0] LenMax =
    (MaxTokLen > 255) ? 8'hff : LenW'(MaxTokLen);

  mode_e               mode_q, mode_d;
  logic [7:0]          held_q, held_d;
  prefix_t             pfx_q, pfx_d;
  logic [LenW-1:0]     rlen_q, rlen_d;
  logic [PosBits-1:0]  rstart_q, rstart_d;
  logic [LineBits-1:0] line_q, line_d;
  logic                halt_q, halt_d;

  // output queue, four entries
  res_t       fifo_q [4];
  logic [2:0] wp_q, rp_q;
  logic [2:0] cnt;
  res_t       r0, r1;
  logic       v0, v1;
  logic       step;
  logic [7:0] c;
  logic       eof;
  logic       consumed;
  logic [LenW-1:0] bump;
  logic [KindW-1:0] sk;

  assign cnt         = wp_q - rp_q;
  assign req_ready_o = (cnt <= 3'd2);
  assign step        = req_valid_i && req_ready_o;
  assign c           = req_char_i;
  assign eof         = req_eoi_i;
  assign bump        = (rlen_q < LenMax) ? rlen_q + 1'b1 : rlen_q;
  assign sk          = single_kind(c);

  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    pfx_d    = pfx_q;
    rlen_d   = rlen_q;
    rstart_d = rstart_q;
    line_d   = line_q;
    halt_d   = halt_q;
    v0 = 1'b0;
    v1 = 1'b0;
    r0 = '0;
    r1 = '0;
    consumed = 1'b0;
    if (!halt_q) begin
      unique case (mode_q)
        MODE_IDENT: begin
          if (!eof && (is_alpha(c) || is_digit(c) || c == "_")) begin
            if (rlen_q < LenW'(PrefixDepth)) pfx_d[rlen_q[2:0]] = c;
            rlen_d = bump;
            consumed = 1'b1;
          end else begin
            v0 = 1'b1;
            r0 = '{word_kind(pfx_q, rlen_q), line_q, rstart_q, rlen_q, ERR_NONE, 1'b0};
            mode_d = MODE_IDLE;
          end
        end
        MODE_NUMBER: begin
          if (!eof && is_digit(c)) begin
            rlen_d = bump;
            consumed = 1'b1;
          end else begin
            v0 = 1'b1;
            r0 = '{KIND_NUMBER, line_q, rstart_q, rlen_q, ERR_NONE, 1'b0};
            mode_d = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          if (eof || c == 8'h0a) begin
            v0 = 1'b1;
            r0 = '{KIND_END, line_q, rstart_q, rlen_q, ERR_STRING, 1'b0};
            halt_d = 1'b1;
            mode_d = MODE_IDLE;
          end else begin
            rlen_d = bump;
            consumed = 1'b1;
            if (c == 8'h22) begin
              v0 = 1'b1;
              r0 = '{KIND_STRING, line_q, rstart_q, bump, ERR_NONE, 1'b0};
              mode_d = MODE_IDLE;
            end
          end
        end
        MODE_COMMENT: begin
          if (eof) begin
            v0 = 1'b1;
            r0 = '{KIND_END, line_q, rstart_q, rlen_q, ERR_COMMENT, 1'b0};
            halt_d = 1'b1;
            mode_d = MODE_IDLE;
          end else begin
            rlen_d = bump;
            consumed = 1'b1;
            if (held_q == "*" && c == "/") begin
              mode_d = MODE_IDLE;
            end else begin
              if (c == 8'h0a) line_d = line_q + 1'b1;
              held_d = c;
            end
          end
        end
        MODE_SYMBOL: begin
          if (!eof && held_q == "/" && c == "*") begin
            mode_d = MODE_COMMENT;
            held_d = "*";
            rlen_d = bump;
            consumed = 1'b1;
          end else if (!eof && c == "=" && held_q != "/") begin
            v0 = 1'b1;
            r0 = '{(held_q == "<") ? 6'd20 : (held_q == "=") ? 6'd21 :
                   (held_q == "!") ? 6'd22 : 6'd23,
                   line_q, rstart_q, LenW'(2), ERR_NONE, 1'b0};
            mode_d = MODE_IDLE;
            consumed = 1'b1;
          end else if (held_q == "!") begin
            v0 = 1'b1;
            r0 = '{KIND_END, line_q, rstart_q, LenW'(1), ERR_SYMBOL, 1'b0};
            halt_d = 1'b1;
            mode_d = MODE_IDLE;
          end else begin
            v0 = 1'b1;
            r0 = '{(held_q == "/") ? 6'd28 : (held_q == "<") ? 6'd19 :
                   (held_q == "=") ? 6'd30 : 6'd24,
                   line_q, rstart_q, LenW'(1), ERR_NONE, 1'b0};
            mode_d = MODE_IDLE;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase

      if (!halt_d && !consumed) begin
        if (eof) begin
          v1 = 1'b1;
          r1 = '{KIND_END, line_d - 1'b1, req_pos_i, '0, ERR_NONE, 1'b0};
          mode_d = MODE_IDLE;
        end else begin
          rstart_d = req_pos_i;
          rlen_d   = LenW'(1);
          if (is_blank(c)) begin
          end else if (c == 8'h0a) begin
            line_d = line_d + 1'b1;
          end else if (is_digit(c)) begin
            mode_d = MODE_NUMBER;
          end else if (is_alpha(c)) begin
            mode_d = MODE_IDENT;
            pfx_d[0] = c;
          end else if (c == 8'h22) begin
            mode_d = MODE_STRING;
          end else if (c == "/" || c == "<" || c == "=" || c == ">" || c == "!") begin
            mode_d = MODE_SYMBOL;
            held_d = c;
          end else if (sk != KIND_END) begin
            v1 = 1'b1;
            r1 = '{sk, line_d, req_pos_i, LenW'(1), ERR_NONE, 1'b0};
          end else begin
            v1 = 1'b1;
            r1 = '{KIND_END, line_d, req_pos_i, LenW'(1), ERR_SYMBOL, 1'b0};
            halt_d = 1'b1;
            mode_d = MODE_IDLE;
          end
        end
      end
    end
    if (v1) r1.last = 1'b1;
    else r0.last = 1'b1;
    if (!v0) begin
      r0 = r1;
      v0 = v1;
      v1 = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      held_q   <= '0;
      rlen_q   <= '0;
      rstart_q <= '0;
      line_q   <= LineBits'(1);
      halt_q   <= 1'b0;
      wp_q     <= '0;
      rp_q     <= '0;
    end else begin
      if (cfg_we_i) line_q <= LineBits'(cfg_data_i);
      if (step) begin
        mode_q   <= mode_d;
        held_q   <= held_d;
        rlen_q   <= rlen_d;
        rstart_q <= rstart_d;
        halt_q   <= halt_d;
        if (!cfg_we_i) line_q <= line_d;
        wp_q     <= wp_q + {1'b0, v0 && v1, v0 && !v1};
      end
      if (pop_i && !empty_o) rp_q <= rp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      pfx_q <= pfx_d;
      if (v0) fifo_q[wp_q[1:0]] <= r0;
      if (v1) fifo_q[wp_q[1:0] + 2'd1] <= r1;
    end
  end

  assign empty_o        = (cnt == 3'd0);
  assign token_kind_o   = fifo_q[rp_q[1:0]].kind;
  assign line_number_o  = fifo_q[rp_q[1:0]].line;
  assign start_offset_o = fifo_q[rp_q[1:0]].start;
  assign token_length_o = fifo_q[rp_q[1:0]].len;
  assign error_code_o   = fifo_q[rp_q[1:0]].err;
  assign last_of_run_o  = fifo_q[rp_q[1:0]].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt <= 3'd4)
    else $error("queue overflow");
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q && step |=> wp_q == $past(wp_q))
    else $error("result after halt");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt cleared");

endmodule

### rtl/core/source_char_lexer.sv
`timescale 1ns / 1ps
// Flow: a byte enters the input register, then is scanned and its results are queued
// when the back end accepts it; the queue head drives the result ports directly.
// Throughput: one byte per cycle while the result queue holds two entries or fewer,
// else the front reports full; the queue has four entries (two results per byte at most).
// Reset clears scan state, positions and queues; the line counter loads 1.
module source_char_lexer import scl_pkg::*; #(
  parameter int unsigned LineBits  = LineBitsDef,
  parameter int unsigned PosBits   = PosBitsDef,
  parameter int unsigned MaxTokLen = MaxTokLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          char_in_i,
  input  logic                end_of_input_i,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data_i,
  output logic                empty,
  input  logic                pop,
  output logic [KindW-1:0]    token_kind_o,
  output logic [LineBits-1:0] line_number_o,
  output logic [PosBits-1:0]  start_offset_o,
  output logic [LenW-1:0]     token_length_o,
  output logic [ErrW-1:0]     error_code_o,
  output logic                last_of_run_o
);

  logic               rq_valid, rq_ready, rq_eoi;
  logic [7:0]         rq_char;
  logic [PosBits-1:0] rq_pos;

  assign cfg_ready = 1'b1;

  scl_front #(.PosBits(PosBits)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .char_in_i, .end_of_input_i,
    .req_valid_o(rq_valid), .req_ready_i(rq_ready),
    .req_char_o(rq_char), .req_eoi_o(rq_eoi), .req_pos_o(rq_pos)
  );

  scl_back #(.LineBits(LineBits), .PosBits(PosBits), .MaxTokLen(MaxTokLen)) u_back (
    .clk_i, .rst_ni,
    .req_valid_i(rq_valid), .req_ready_o(rq_ready),
    .req_char_i(rq_char), .req_eoi_i(rq_eoi), .req_pos_i(rq_pos),
    .cfg_we_i(cfg_valid && cfg_ready), .cfg_data_i,
    .pop_i(pop), .empty_o(empty),
    .token_kind_o, .line_number_o, .start_offset_o,
    .token_length_o, .error_code_o, .last_of_run_o
  );

endmodule

### tb/source_char_lexer_tb.sv
`timescale 1ns / 1ps
module source_char_lexer_tb;
  import scl_pkg::*;

  typedef enum logic [5:0] {
    TK_END, TK_INT, TK_VOID, TK_STRKW, TK_IF, TK_ELSE, TK_WHILE, TK_RETURN, TK_WRITE,
    TK_WRITELN, TK_READ, TK_SEMI, TK_COMMA, TK_LBRK, TK_RBRK, TK_LBRACE, TK_RBRACE,
    TK_LPAR, TK_RPAR, TK_LT, TK_LE, TK_EQEQ, TK_NE, TK_GE, TK_GT, TK_PLUS, TK_MINUS,
    TK_STAR, TK_SLASH, TK_PCT, TK_ASSIGN, TK_AMP, TK_IDENT, TK_NUMBER, TK_STRING
  } tok_kind_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [19:0] start;
    logic [7:0]  len;
    logic [1:0]  err;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eoi;
  } src_item_t;

  class token_scoreboard;
    token_t     tokens_due[$];
    int         mismatches;
    logic [15:0] first_line;
    mode_e      mode;
    logic [7:0] held;
    logic [7:0] prefix [PrefixDepth];
    int         run_len;
    logic [19:0] run_start;
    logic [15:0] line_cnt;
    logic [19:0] pos;
    bit         halted;
    int         nres;
    string      keywords [10];

    function new();
      keywords = '{"int", "void", "string", "if", "else", "while", "return", "write",
                   "writeln", "read"};
      first_line = 16'd1;
      mode = MODE_IDLE;
      held = 8'd0;
      foreach (prefix[i]) prefix[i] = 8'd0;
      run_len = 0;
      run_start = '0;
      line_cnt = 16'd1;
      pos = '0;
      halted = 0;
      mismatches = 0;
    endfunction

    function void set_first_line(logic [15:0] v);
      first_line = v;
      line_cnt = v;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function void add_token(logic [5:0] k, logic [15:0] l, logic [19:0] s, int n,
                            logic [1:0] e);
      token_t t;
      if (nres >= 2) return;
      t.kind = k;
      t.line = l;
      t.start = s;
      t.len = n[7:0];
      t.err = e;
      t.last = 1'b0;
      tokens_due.push_back(t);
      nres++;
    endfunction

    function void halt(logic [1:0] code, logic [19:0] s, int n);
      add_token(TK_END, line_cnt, s, n, code);
      halted = 1;
      mode = MODE_IDLE;
    endfunction

    function void grow();
      if (run_len < MaxTokLenDef) run_len++;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit blank(logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d;
    endfunction

    function logic [5:0] punct_kind(logic [7:0] c);
      case (c)
        ";": return TK_SEMI;
        ",": return TK_COMMA;
        "[": return TK_LBRK;
        "]": return TK_RBRK;
        "{": return TK_LBRACE;
        "}": return TK_RBRACE;
        "(": return TK_LPAR;
        ")": return TK_RPAR;
        "+": return TK_PLUS;
        "-": return TK_MINUS;
        "*": return TK_STAR;
        "%": return TK_PCT;
        "&": return TK_AMP;
        default: return TK_END;
      endcase
    endfunction

    function void flush_word();
      logic [5:0] k;
      bit hit;
      k = TK_IDENT;
      if (run_len <= PrefixDepth) begin
        for (int w = 0; w < 10; w++) begin
          if (keywords[w].len() == run_len && k == TK_IDENT) begin
            hit = 1;
            for (int i = 0; i < run_len; i++)
              if (prefix[i] != keywords[w][i]) hit = 0;
            if (hit) k = TK_INT + w;
          end
        end
      end
      add_token(k, line_cnt, run_start, run_len, ERR_NONE);
    endfunction

    function void start_token(logic [7:0] c, logic [19:0] p);
      logic [5:0] k;
      run_start = p;
      run_len = 1;
      if (blank(c)) return;
      if (c == 8'h0a) begin
        line_cnt++;
        return;
      end
      if (digit(c)) begin
        mode = MODE_NUMBER;
        return;
      end
      if (alpha(c)) begin
        mode = MODE_IDENT;
        prefix[0] = c;
        return;
      end
      if (c == "\"") begin
        mode = MODE_STRING;
        return;
      end
      if (c == "/" || c == "<" || c == "=" || c == ">" || c == "!") begin
        mode = MODE_SYMBOL;
        held = c;
        return;
      end
      k = punct_kind(c);
      if (k != TK_END) add_token(k, line_cnt, p, 1, ERR_NONE);
      else halt(ERR_SYMBOL, p, 1);
    endfunction

    function void note_request(logic [7:0] c, logic eoi);
      logic [19:0] p;
      bit taken;
      p = pos;
      taken = 0;
      nres = 0;
      if (halted) return;
      case (mode)
        MODE_IDENT: begin
          if (!eoi && (alpha(c) || digit(c) || c == "_")) begin
            if (run_len < PrefixDepth) prefix[run_len] = c;
            grow();
            taken = 1;
          end else begin
            flush_word();
            mode = MODE_IDLE;
          end
        end
        MODE_NUMBER: begin
          if (!eoi && digit(c)) begin
            grow();
            taken = 1;
          end else begin
            add_token(TK_NUMBER, line_cnt, run_start, run_len, ERR_NONE);
            mode = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          if (eoi || c == 8'h0a) halt(ERR_STRING, run_start, run_len);
          else begin
            grow();
            if (c == "\"") begin
              add_token(TK_STRING, line_cnt, run_start, run_len, ERR_NONE);
              mode = MODE_IDLE;
            end
            taken = 1;
          end
        end
        MODE_COMMENT: begin
          if (eoi) halt(ERR_COMMENT, run_start, run_len);
          else begin
            grow();
            if (held == "*" && c == "/") mode = MODE_IDLE;
            else begin
              if (c == 8'h0a) line_cnt++;
              held = c;
            end
            taken = 1;
          end
        end
        MODE_SYMBOL: begin
          if (!eoi && held == "/" && c == "*") begin
            mode = MODE_COMMENT;
            held = "*";
            grow();
            taken = 1;
          end else if (!eoi && c == "=" && held != "/") begin
            add_token(held == "<" ? TK_LE : held == "=" ? TK_EQEQ : held == "!" ? TK_NE :
                      TK_GE, line_cnt, run_start, 2, ERR_NONE);
            mode = MODE_IDLE;
            taken = 1;
          end else if (held == "!") begin
            halt(ERR_SYMBOL, run_start, 1);
          end else begin
            add_token(held == "/" ? TK_SLASH : held == "<" ? TK_LT : held == "=" ? TK_ASSIGN :
                      TK_GT, line_cnt, run_start, 1, ERR_NONE);
            mode = MODE_IDLE;
          end
        end
        default: mode = MODE_IDLE;
      endcase
      if (!halted && !taken) begin
        if (eoi) begin
          add_token(TK_END, line_cnt - 16'd1, p, 0, ERR_NONE);
          mode = MODE_IDLE;
        end else begin
          start_token(c, p);
        end
      end
      if (!eoi) pos++;
      if (nres > 0) tokens_due[$].last = 1'b1;
    endfunction

    function void check_result(token_t got);
      token_t want;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = tokens_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_in_i = 8'd0;
  logic        end_of_input_i = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data_i = 16'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [5:0]  token_kind_o;
  logic [15:0] line_number_o;
  logic [19:0] start_offset_o;
  logic [7:0]  token_length_o;
  logic [1:0]  error_code_o;
  logic        last_of_run_o;

  token_scoreboard sb;
  src_item_t       src_q[$];
  bit              calm = 0;
  bit              hold_req = 0;
  int              stall_cycles = 0;

  source_char_lexer dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .char_in_i(char_in_i),
    .end_of_input_i(end_of_input_i), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data_i(cfg_data_i), .empty(empty), .pop(pop), .token_kind_o(token_kind_o),
    .line_number_o(line_number_o), .start_offset_o(start_offset_o),
    .token_length_o(token_length_o), .error_code_o(error_code_o),
    .last_of_run_o(last_of_run_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles > 4000) begin
      $display("source_char_lexer_tb NOT OK");
      $finish;
    end
  end

  initial begin
    token_t t;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 0;
      end
      pop <= (calm || $urandom_range(99) >= 11);
      @(posedge clk_i);
      if (pop && !empty) begin
        t = '{token_kind_o, line_number_o, start_offset_o, token_length_o, error_code_o,
              last_of_run_o};
        sb.check_result(t);
      end
    end
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back('{s[i], 1'b0});
  endfunction

  function automatic void add_end();
    src_q.push_back('{8'($urandom), 1'b1});
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(3))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      2: return 8'($urandom_range("0", "9"));
      default: return "_";
    endcase
  endfunction

  function automatic void add_random_token();
    string kws [10] = '{"int", "void", "string", "if", "else", "while", "return", "write",
                        "writeln", "read"};
    string puncts = ";,[]{}()+-*%&";
    string pairs [4] = '{"<=", "==", "!=", ">="};
    string leads = "/<=>";
    string blanks = " \t\v\f\r";
    logic [7:0] b;
    int n;
    case ($urandom_range(12))
      0: add_text(kws[$urandom_range(9)]);
      1: begin
        src_q.push_back('{($urandom_range(1) ? 8'($urandom_range("a", "z")) :
                          8'($urandom_range("A", "Z"))), 1'b0});
        n = ($urandom_range(30) == 0) ? $urandom_range(250, 300) : $urandom_range(10);
        repeat (n) src_q.push_back('{word_char(), 1'b0});
      end
      2: begin
        n = ($urandom_range(40) == 0) ? $urandom_range(250, 270) : $urandom_range(1, 6);
        repeat (n) src_q.push_back('{8'($urandom_range("0", "9")), 1'b0});
      end
      3: begin
        add_text("\"");
        repeat ($urandom_range(8)) begin
          do b = 8'($urandom); while (b == "\"" || b == 8'h0a);
          src_q.push_back('{b, 1'b0});
        end
        add_text("\"");
      end
      4: begin
        add_text("/*");
        repeat ($urandom_range(8)) begin
          do b = 8'($urandom); while (b == "/");
          src_q.push_back('{b, 1'b0});
        end
        add_text("*/");
      end
      5: src_q.push_back('{puncts[$urandom_range(puncts.len() - 1)], 1'b0});
      6: add_text(pairs[$urandom_range(3)]);
      7: src_q.push_back('{leads[$urandom_range(3)], 1'b0});
      8, 9: add_text("\n");
      10: add_text("12ab");
      11: begin
        add_end();
        return;
      end
      default: ;
    endcase
    src_q.push_back('{blanks[$urandom_range(4)], 1'b0});
  endfunction

  task automatic send_request(src_item_t it);
    if (!calm && $urandom_range(99) < 11) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    char_in_i <= it.c;
    end_of_input_i <= it.eoi;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_request(it.c, it.eoi);
  endtask

  task automatic send_all();
    while (src_q.size() > 0) send_request(src_q.pop_front());
    push <= 1'b0;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_first_line(logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    sb.set_first_line(v);
  endtask

  task automatic random_phase(int nbytes);
    while (src_q.size() < nbytes) add_random_token();
    send_all();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: keywords, words, numbers, strings, comments, every symbol, end marks
    write_first_line(16'hffff);
    add_text("int void string if else while return write writeln read x_1 12ab \"s\" ");
    add_text("/*/ /* a*b\n */ ; , [ ] { } ( ) < <= == != >= > + - * / % = & \n");
    add_end();
    add_end();
    send_all();

    write_first_line(16'd0);
    add_text("\n");
    add_end();
    random_phase(120);

    write_first_line(16'd1);
    calm = 1;
    random_phase(150);
    calm = 0;

    write_first_line(16'($urandom));
    hold_req = 1;
    random_phase(150);

    drain();
    random_phase(150);

    // halt: the block stays stopped until reset
    case ($urandom_range(5))
      0: add_text("\"ab\n");
      1: begin
        add_text("/* x");
        add_end();
      end
      2: add_text("#");
      3: add_text("! ");
      4: add_text("_a");
      default: src_q.push_back('{8'($urandom_range(128, 255)), 1'b0});
    endcase
    repeat (5) add_random_token();
    send_all();

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("source_char_lexer_tb OK");
    end else begin
      $display("source_char_lexer_tb NOT OK");
    end
    $finish;
  end

endmodule
